// File: hdl/ctcv_pkg.sv
`default_nettype none
package ctcv_pkg;

  localparam int KW = 14;
  localparam int GW = 8;

  localparam logic [KW-1:0] KELVIN_MIN    = 14'd1000;
  localparam logic [KW-1:0] KELVIN_MAX    = 14'd10000;
  localparam logic [KW-1:0] KELVIN_SPLIT  = 14'd6500;
  localparam logic [KW-1:0] KELVIN_NOBLUE = 14'd1900;
  localparam logic [KW-1:0] SNAP_STEP     = 14'd50;
  localparam logic [12:0]   SNAP_RECIP    = 13'd5243;
  localparam int            SNAP_SHIFT    = 18;
  localparam logic [3:0]    SEARCH_STEPS  = 4'd10;
  localparam logic [GW-1:0] GAIN_MAX      = 8'd255;
  localparam logic [7:0]    KELVIN_DIV    = 8'd100;

  typedef enum logic [1:0] {
    FIT_RED      = 2'd0,
    FIT_GREEN_LO = 2'd1,
    FIT_GREEN_HI = 2'd2,
    FIT_BLUE     = 2'd3
  } fit_sel_t;

  localparam logic [6:0] FIT_OFFSET [4] = '{7'd55, 7'd2, 7'd50, 7'd10};

  // a, b, c per fit in units of 1e-9
  localparam longint COEF_TBL [12] = '{
    64'sd351976905668,  64'sd114206454, -64'sd40253663093,
    -64'sd155254855627, -64'sd445969505, 64'sd104492161994,
    64'sd325449412571,  64'sd79434565,  -64'sd28085296351,
    -64'sd254769351841, 64'sd827409606, 64'sd115679944011
  };

  typedef struct packed {
    logic          start;
    fit_sel_t      sel;
    logic [KW-1:0] kelvin;
  } fit_cmd_t;

  typedef struct packed {
    logic          done;
    logic [GW-1:0] gain;
  } fit_sts_t;

  function automatic longint unsigned udiv(longint unsigned a, longint unsigned b, int bits);
    longint unsigned r;
    longint unsigned q;
    r = 0;
    q = 0;
    for (int k = bits - 1; k >= 0; k--) begin
      r = (r << 1) | ((a >> k) & 64'd1);
      if (r >= b) begin
        r = r - b;
        q = q | (64'd1 << k);
      end
    end
    return q;
  endfunction

  function automatic longint unsigned coef_mag(longint v, int frac);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    return ((mag << frac) + 64'd500000000) / 64'd1000000000;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ctcv_fit.sv
`default_nettype none
module ctcv_fit #(
  parameter int LOG_TABLE_ENTRIES = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctcv_pkg::fit_cmd_t   cmd,
  output ctcv_pkg::fit_sts_t        sts
);

  localparam int F    = FRAC_BITS;
  localparam int N    = LOG_TABLE_ENTRIES;
  localparam int XW   = F + 7;
  localparam int EW   = $clog2(XW) + 2;
  localparam int LW   = F + EW + 1;
  localparam int CW   = F + 9;
  localparam int PW   = CW + LW;
  localparam int SW   = F + 13;
  localparam int AW   = $clog2(N + 1);
  localparam int TW   = XW - 1 + AW;
  localparam int CNTW = $clog2(LW + 1);
  localparam int EOFF = XW - 1 - F;
  localparam int RS   = 24;
  localparam int MW   = F + 18;
  localparam int KPW  = ctcv_pkg::KW + MW;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (F + RS)) + 64'd99) / 64'd100);

  typedef logic [F-1:0]  rom_t  [N+1];
  typedef logic [CW-1:0] mag4_t [4];

  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned z, z2, pw, sum;
    for (int i = 0; i <= N; i++) begin
      z   = ctcv_pkg::udiv(longint'(i) << 30, longint'(2 * N + i), 46);
      z2  = (z * z) >> 30;
      pw  = z;
      sum = 0;
      for (int k = 1; k <= 41; k += 2) begin
        sum = sum + ctcv_pkg::udiv(pw, longint'(k), 32);
        pw  = (pw * z2) >> 30;
      end
      sum  = sum * 2;
      sum  = (sum + (64'd1 << (29 - F))) >> (30 - F);
      r[i] = sum[F-1:0];
    end
    return r;
  endfunction

  function automatic mag4_t mags(int j);
    mag4_t m;
    longint unsigned v;
    for (int s = 0; s < 4; s++) begin
      v    = ctcv_pkg::coef_mag(ctcv_pkg::COEF_TBL[s*3+j], F);
      m[s] = v[CW-1:0];
    end
    return m;
  endfunction

  function automatic logic [3:0] negs(int j);
    logic [3:0] n;
    for (int s = 0; s < 4; s++) n[s] = ctcv_pkg::COEF_TBL[s*3+j] < 0;
    return n;
  endfunction

  localparam rom_t       LN_ROM = build_rom();
  localparam logic [F-1:0] LN2  = LN_ROM[N];
  localparam mag4_t      A_MAG  = mags(0);
  localparam mag4_t      B_MAG  = mags(1);
  localparam mag4_t      C_MAG  = mags(2);
  localparam logic [3:0] A_NEG  = negs(0);
  localparam logic [3:0] B_NEG  = negs(1);
  localparam logic [3:0] C_NEG  = negs(2);

  typedef enum logic [3:0] {
    P_IDLE, P_DIV, P_X, P_NORM, P_RD0, P_RD1, P_RD2, P_MI, P_MB, P_MC, P_SUM
  } phase_t;

  phase_t                phase;
  logic [CNTW-1:0]       cnt;
  ctcv_pkg::fit_sel_t    sel;
  logic [ctcv_pkg::KW-1:0] kq;
  logic [XW-1:0]         dq;
  logic [XW-1:0]         xv;
  logic [XW-1:0]         xn;
  logic [CNTW-1:0]       sh;
  logic [XW-2:0]         remn;
  logic [AW-1:0]         rom_addr;
  logic [F-1:0]          rom_q;
  logic [F-1:0]          lo;
  logic signed [LW-1:0]  lnv;
  logic [PW-1:0]         mc;
  logic [LW-1:0]         mp;
  logic [PW-1:0]         pr;
  logic signed [SW-1:0]  acc;
  logic                  done;
  logic [7:0]            gain;

  logic [KPW-1:0]        kprod;
  logic [XW:0]           off_fx;
  logic [XW:0]           xs;
  logic [TW-1:0]         tn;
  logic [AW-1:0]         idx_c;
  logic signed [EW-1:0]  e;
  logic signed [LW-1:0]  eln;
  logic [PW-1:0]         pr_nx;
  logic [F-1:0]          interp;
  logic [SW-2:0]         bxm;
  logic [SW-2:0]         clm;
  logic signed [SW-1:0]  a_s;
  logic signed [SW-1:0]  bx_s;
  logic signed [SW-1:0]  cl_s;
  logic [LW-1:0]         ln_abs;
  logic [SW-2-F:0]       v;

  assign kprod  = KPW'(kq) * KPW'(RECIP);
  assign off_fx = (XW+1)'(ctcv_pkg::FIT_OFFSET[sel]) << F;
  assign xs     = {1'b0, dq} - off_fx;
  assign tn     = TW'(xn[XW-2:0]) * TW'(N);
  assign idx_c  = (tn[TW-1:XW-1] >= AW'(N)) ? AW'(N - 1) : tn[TW-1:XW-1];
  assign e      = EW'(EOFF) - EW'(sh);
  assign eln    = LW'(e) * $signed(LW'({1'b0, LN2}));
  assign pr_nx  = mp[0] ? pr + mc : pr;
  assign interp = pr_nx[XW-1 +: F];
  assign bxm    = pr_nx[F +: SW-1];
  assign clm    = pr_nx[F +: SW-1];
  assign a_s    = A_NEG[sel] ? -$signed({1'b0, (SW-1)'(A_MAG[sel])})
                             :  $signed({1'b0, (SW-1)'(A_MAG[sel])});
  assign bx_s   = B_NEG[sel] ? -$signed({1'b0, bxm}) : $signed({1'b0, bxm});
  assign cl_s   = (C_NEG[sel] ^ lnv[LW-1]) ? -$signed({1'b0, clm}) : $signed({1'b0, clm});
  assign ln_abs = lnv[LW-1] ? LW'(-lnv) : LW'(lnv);
  assign v      = acc[SW-2:F];

  assign sts.done = done;
  assign sts.gain = gain;

  always_ff @(posedge clk) begin
    rom_q <= LN_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            sel   <= cmd.sel;
            kq    <= cmd.kelvin;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          dq    <= kprod[RS +: XW];
          phase <= P_X;
        end
        P_X: begin
          if (xs[XW] || xs == '0) begin
            xv <= XW'(1);
            xn <= XW'(1);
          end else begin
            xv <= xs[XW-1:0];
            xn <= xs[XW-1:0];
          end
          sh    <= '0;
          phase <= P_NORM;
        end
        P_NORM: begin
          if (xn[XW-1]) begin
            remn     <= tn[XW-2:0];
            rom_addr <= idx_c;
            phase    <= P_RD0;
          end else begin
            xn <= xn << 1;
            sh <= sh + 1'b1;
          end
        end
        P_RD0: begin
          rom_addr <= rom_addr + 1'b1;
          phase    <= P_RD1;
        end
        P_RD1: begin
          lo    <= rom_q;
          phase <= P_RD2;
        end
        P_RD2: begin
          mc    <= PW'(rom_q - lo);
          mp    <= LW'(remn);
          pr    <= '0;
          cnt   <= CNTW'(XW - 1);
          phase <= P_MI;
        end
        P_MI: begin
          mc  <= mc << 1;
          mp  <= mp >> 1;
          pr  <= pr_nx;
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            lnv   <= eln + $signed(LW'(lo)) + $signed(LW'(interp));
            mc    <= PW'(B_MAG[sel]);
            mp    <= LW'(xv);
            pr    <= '0;
            cnt   <= CNTW'(XW);
            phase <= P_MB;
          end
        end
        P_MB: begin
          mc  <= mc << 1;
          mp  <= mp >> 1;
          pr  <= pr_nx;
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            acc   <= a_s + bx_s;
            mc    <= PW'(C_MAG[sel]);
            mp    <= ln_abs;
            pr    <= '0;
            cnt   <= CNTW'(LW);
            phase <= P_MC;
          end
        end
        P_MC: begin
          mc  <= mc << 1;
          mp  <= mp >> 1;
          pr  <= pr_nx;
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            acc   <= acc + cl_s;
            phase <= P_SUM;
          end
        end
        P_SUM: begin
          if (acc[SW-1]) gain <= '0;
          else if (v > (SW-1-F)'(ctcv_pkg::GAIN_MAX)) gain <= ctcv_pkg::GAIN_MAX;
          else gain <= v[7:0];
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/ctcv_ctrl.sv
`default_nettype none
module ctcv_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     req_type,
  input  wire logic [ctcv_pkg::KW-1:0]  kelvin_in,
  input  wire logic [ctcv_pkg::GW-1:0]  red_in,
  input  wire logic [ctcv_pkg::GW-1:0]  blue_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [ctcv_pkg::GW-1:0]       red_gain,
  output logic [ctcv_pkg::GW-1:0]       green_gain,
  output logic [ctcv_pkg::GW-1:0]       blue_gain,
  output logic [ctcv_pkg::KW-1:0]       kelvin_out,
  output ctcv_pkg::fit_cmd_t            fit_cmd,
  input  wire ctcv_pkg::fit_sts_t       fit_sts
);

  localparam int KW = ctcv_pkg::KW;
  localparam int GW = ctcv_pkg::GW;

  typedef enum logic [3:0] {
    S_IDLE, S_FR, S_FG, S_FB, S_MID, S_SR, S_SB, S_DECIDE,
    S_SNAP, S_DR, S_DB, S_UR, S_UB, S_DONE
  } state_t;

  typedef enum logic [1:0] {G_NONE, G_RED, G_GREEN, G_BLUE} gkind_t;

  state_t         state;
  logic           inv;
  logic [KW-1:0]  t, lo, hi, down, up;
  logic [GW-1:0]  r_in, b_in, gr, gg, gb;
  logic [3:0]     n;
  logic           started;

  gkind_t              gkind;
  logic [KW-1:0]       gk;
  logic                special;
  logic [GW-1:0]       fixed;
  ctcv_pkg::fit_sel_t  sel;
  logic                gready;
  logic [GW-1:0]       gval;
  logic [KW-1:0]       ksat;
  logic [26:0]         qprod;
  logic [KW-1:0]       dn;
  logic [13:0]         dn_wide;

  always_comb begin
    unique case (state)
      S_FR, S_SR, S_DR, S_UR: gkind = G_RED;
      S_FG:                   gkind = G_GREEN;
      S_FB, S_SB, S_DB, S_UB: gkind = G_BLUE;
      default:                gkind = G_NONE;
    endcase
    if (state == S_DR || state == S_DB) gk = down;
    else if (state == S_UR || state == S_UB) gk = up;
    else gk = t;
    special = 1'b0;
    fixed   = '0;
    sel     = ctcv_pkg::FIT_RED;
    unique case (gkind)
      G_RED: begin
        special = gk <= ctcv_pkg::KELVIN_SPLIT;
        fixed   = ctcv_pkg::GAIN_MAX;
      end
      G_GREEN: begin
        sel = (gk <= ctcv_pkg::KELVIN_SPLIT) ? ctcv_pkg::FIT_GREEN_LO
                                             : ctcv_pkg::FIT_GREEN_HI;
      end
      G_BLUE: begin
        sel     = ctcv_pkg::FIT_BLUE;
        special = gk <= ctcv_pkg::KELVIN_NOBLUE || gk >= ctcv_pkg::KELVIN_SPLIT;
        fixed   = (gk <= ctcv_pkg::KELVIN_NOBLUE) ? '0 : ctcv_pkg::GAIN_MAX;
      end
      default: special = 1'b0;
    endcase
    gready = gkind != G_NONE && (special || (started && fit_sts.done));
    gval   = special ? fixed : fit_sts.gain;
  end

  assign fit_cmd.start  = gkind != G_NONE && !special && !started;
  assign fit_cmd.sel    = sel;
  assign fit_cmd.kelvin = gk;

  assign in_ready = state == S_IDLE;
  assign ksat     = (kelvin_in < ctcv_pkg::KELVIN_MIN) ? ctcv_pkg::KELVIN_MIN :
                    (kelvin_in > ctcv_pkg::KELVIN_MAX) ? ctcv_pkg::KELVIN_MAX : kelvin_in;
  assign qprod    = 27'(t) * 27'(ctcv_pkg::SNAP_RECIP);
  assign dn_wide  = 14'(qprod[26:ctcv_pkg::SNAP_SHIFT]) * ctcv_pkg::SNAP_STEP;
  assign dn       = dn_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (gkind != G_NONE && !special) begin
        if (!started) started <= 1'b1;
        else if (fit_sts.done) started <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            inv  <= req_type;
            r_in <= red_in;
            b_in <= blue_in;
            if (!req_type) begin
              t     <= ksat;
              state <= S_FR;
            end else begin
              lo    <= (blue_in == ctcv_pkg::GAIN_MAX) ? ctcv_pkg::KELVIN_SPLIT
                                                       : ctcv_pkg::KELVIN_MIN;
              hi    <= (red_in == ctcv_pkg::GAIN_MAX) ? ctcv_pkg::KELVIN_SPLIT
                                                      : ctcv_pkg::KELVIN_MAX;
              n     <= '0;
              state <= S_MID;
            end
          end
        end
        S_FR: if (gready) begin gr <= gval; state <= S_FG; end
        S_FG: if (gready) begin gg <= gval; state <= S_FB; end
        S_FB: if (gready) begin gb <= gval; state <= S_DONE; end
        S_MID: begin
          t     <= KW'((15'(lo) + 15'(hi)) >> 1);
          state <= S_SR;
        end
        S_SR: if (gready) begin gr <= gval; state <= S_SB; end
        S_SB: if (gready) begin gb <= gval; state <= S_DECIDE; end
        S_DECIDE: begin
          if (16'(gb) * 16'(r_in) > 16'(b_in) * 16'(gr)) hi <= t;
          else lo <= t;
          n <= n + 1'b1;
          if ((gr == r_in && gb == b_in) || n == ctcv_pkg::SEARCH_STEPS - 1'b1)
            state <= S_SNAP;
          else
            state <= S_MID;
        end
        S_SNAP: begin
          if (dn != t) begin
            down  <= dn;
            up    <= dn + ctcv_pkg::SNAP_STEP;
            state <= S_DR;
          end else begin
            state <= S_DONE;
          end
        end
        S_DR: if (gready) state <= (gval == r_in) ? S_DB : S_UR;
        S_DB: begin
          if (gready) begin
            if (gval == b_in) begin
              t     <= down;
              state <= S_DONE;
            end else begin
              state <= S_UR;
            end
          end
        end
        S_UR: if (gready) state <= (gval == r_in) ? S_UB : S_DONE;
        S_UB: begin
          if (gready) begin
            if (gval == b_in) t <= up;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            red_gain   <= inv ? '0 : gr;
            green_gain <= inv ? '0 : gg;
            blue_gain  <= inv ? '0 : gb;
            kelvin_out <= t;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/color_temperature_rgb_converter_core.sv
`default_nettype none
// channel   | dir | tdata (low bit up)                              | tuser
// s_axis    | in  | kelvin_in[13:0] red_in[21:14] blue_in[29:22]     | req_type
// m_axis    | out | red[7:0] green[15:8] blue[23:16] kelvin[37:24]   | -
//
// A fitted gain is made in the shared fit unit: a reciprocal multiply for kelvin/100, a
// normalize shift, two ln table reads and three shift-add products; a fixed gain (0 or
// 255) bypasses the fit unit. Forward items take up to three gains; inverse items take two
// gains per bisection step (at most ten), plus the midpoint and decide states of each step,
// one snap check state and up to four snap gains, one item at a time.
// Reset is synchronous; the result register holds until taken while the next item
// is accepted.
module color_temperature_rgb_converter_core #(
  parameter int LOG_TABLE_ENTRIES = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // kelvin_in, red_in, blue_in
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // red_gain, green_gain, blue_gain, kelvin_out
);

  ctcv_pkg::fit_cmd_t fit_cmd;
  ctcv_pkg::fit_sts_t fit_sts;
  logic [7:0]  red_gain, green_gain, blue_gain;
  logic [13:0] kelvin_out;

  ctcv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .req_type   (s_axis_tuser),
    .kelvin_in  (s_axis_tdata[13:0]),
    .red_in     (s_axis_tdata[21:14]),
    .blue_in    (s_axis_tdata[29:22]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .red_gain   (red_gain),
    .green_gain (green_gain),
    .blue_gain  (blue_gain),
    .kelvin_out (kelvin_out),
    .fit_cmd    (fit_cmd),
    .fit_sts    (fit_sts)
  );

  ctcv_fit #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) u_fit (
    .clk (clk),
    .rst (rst),
    .cmd (fit_cmd),
    .sts (fit_sts)
  );

  assign m_axis_tdata = {2'b00, kelvin_out, blue_gain, green_gain, red_gain};

endmodule
`default_nettype wire
